// ----- src/osm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg
// Shared constants, codes and types for the sorted multiset block.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W    = 32;
    localparam int RANK_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // common width for rank against count compares
    localparam int WIDE_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;

    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RANK = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY_WAIT,
        S_INS_SCAN,
        S_INS_PUT,
        S_REM_SCAN,
        S_FINISH
    } t_state;

endpackage

// ----- src/osm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module osm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/order_statistic_multiset.sv -----
`timescale 1ns / 1ps
// Query reads the RAM in S_QUERY_WAIT; insert shifts each larger entry up in S_INS_SCAN,
//   then S_INS_PUT if all are larger; remove compacts in S_REM_SCAN; all end in S_FINISH.
// One item at a time: the next transfer is taken the cycle after the result loads;
//   a result still held in the output register delays only the load of the next one.
// Synchronous active-low reset clears the count and control; the key RAM is not
//   cleared, entries at or beyond the count are never used.
// ----------------------------------------------------------------------------
// order_statistic_multiset
// Bounded sorted multiset of signed keys with insert, remove-all and k-th
// largest query, held in ascending order in a single RAM.
// ----------------------------------------------------------------------------
module order_statistic_multiset (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [osm_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [osm_pkg::KEY_W-1:0]    i_key,
    input  logic [osm_pkg::RANK_W-1:0]          i_rank,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [osm_pkg::KEY_W-1:0]    o_value,
    output logic [osm_pkg::COUNT_W-1:0]         o_stored_count,
    output logic [osm_pkg::STATUS_W-1:0]        o_status
);

    osm_pkg::t_state r_state, n_state;

    logic [osm_pkg::CNT_W-1:0]          r_count, n_count;
    logic signed [osm_pkg::KEY_W-1:0]   r_key, n_key;
    logic [osm_pkg::ADDR_W-1:0]         r_pos, n_pos;
    logic [osm_pkg::CNT_W-1:0]          r_rd, n_rd;
    logic [osm_pkg::CNT_W-1:0]          r_w, n_w;
    logic signed [osm_pkg::KEY_W-1:0]   r_res_value, n_res_value;
    logic [osm_pkg::STATUS_W-1:0]       r_res_status, n_res_status;

    logic                               r_out_valid, n_out_valid;
    logic signed [osm_pkg::KEY_W-1:0]   r_out_value, n_out_value;
    logic [osm_pkg::COUNT_W-1:0]        r_out_count, n_out_count;
    logic [osm_pkg::STATUS_W-1:0]       r_out_status, n_out_status;

    logic                               ram_we;
    logic [osm_pkg::ADDR_W-1:0]         ram_waddr;
    logic signed [osm_pkg::KEY_W-1:0]   ram_wdata;
    logic [osm_pkg::ADDR_W-1:0]         ram_raddr;
    logic [osm_pkg::KEY_W-1:0]          ram_rdata;
    logic signed [osm_pkg::KEY_W-1:0]   rd_key;

    logic                               in_xfer;
    logic                               out_load;
    logic [osm_pkg::WIDE_W-1:0]         rank_wide;
    logic [osm_pkg::WIDE_W-1:0]         count_wide;
    logic [osm_pkg::WIDE_W-1:0]         query_idx;

    osm_ram #(
        .WIDTH (osm_pkg::KEY_W),
        .DEPTH (osm_pkg::CAPACITY)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key     = $signed(ram_rdata);
    assign o_ready    = (r_state == osm_pkg::S_IDLE);
    assign in_xfer    = i_valid && o_ready;
    assign out_load   = (r_state == osm_pkg::S_FINISH) && (!r_out_valid || i_ready);
    assign rank_wide  = osm_pkg::WIDE_W'(i_rank);
    assign count_wide = osm_pkg::WIDE_W'(r_count);
    assign query_idx  = count_wide - rank_wide;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            osm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_cmd)
                        osm_pkg::CMD_QUERY: begin
                            if (i_rank == '0 || rank_wide > count_wide) begin
                                n_state = osm_pkg::S_FINISH;
                            end else begin
                                n_state = osm_pkg::S_QUERY_WAIT;
                            end
                        end
                        osm_pkg::CMD_INSERT: begin
                            if (r_count == osm_pkg::CNT_W'(osm_pkg::CAPACITY)
                                || r_count == '0) begin
                                n_state = osm_pkg::S_FINISH;
                            end else begin
                                n_state = osm_pkg::S_INS_SCAN;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_state = osm_pkg::S_FINISH;
                            end else begin
                                n_state = osm_pkg::S_REM_SCAN;
                            end
                        end
                    endcase
                end
            end
            osm_pkg::S_QUERY_WAIT: begin
                n_state = osm_pkg::S_FINISH;
            end
            osm_pkg::S_INS_SCAN: begin
                if (rd_key > r_key) begin
                    if (r_pos == osm_pkg::ADDR_W'(1)) begin
                        n_state = osm_pkg::S_INS_PUT;
                    end
                end else begin
                    n_state = osm_pkg::S_FINISH;
                end
            end
            osm_pkg::S_INS_PUT: begin
                n_state = osm_pkg::S_FINISH;
            end
            osm_pkg::S_REM_SCAN: begin
                if (r_rd == r_count) begin
                    n_state = osm_pkg::S_FINISH;
                end
            end
            osm_pkg::S_FINISH: begin
                if (out_load) begin
                    n_state = osm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = osm_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, RAM controls and output register
    always_comb begin
        n_count      = r_count;
        n_key        = r_key;
        n_pos        = r_pos;
        n_rd         = r_rd;
        n_w          = r_w;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = r_pos;
        ram_wdata    = r_key;
        ram_raddr    = r_pos - osm_pkg::ADDR_W'(2);

        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            osm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_key        = i_key;
                    n_res_value  = '0;
                    n_res_status = osm_pkg::ST_OK;
                    case (i_cmd)
                        osm_pkg::CMD_QUERY: begin
                            ram_raddr = query_idx[osm_pkg::ADDR_W-1:0];
                            if (i_rank == '0 || rank_wide > count_wide) begin
                                n_res_status = osm_pkg::ST_BAD_RANK;
                            end
                        end
                        osm_pkg::CMD_INSERT: begin
                            if (r_count == osm_pkg::CNT_W'(osm_pkg::CAPACITY)) begin
                                n_res_status = osm_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = i_key;
                                n_count   = osm_pkg::CNT_W'(1);
                            end else begin
                                // r_pos is the slot the next entry may move into
                                ram_raddr = osm_pkg::ADDR_W'(r_count - osm_pkg::CNT_W'(1));
                                n_pos     = osm_pkg::ADDR_W'(r_count);
                            end
                        end
                        default: begin
                            ram_raddr = '0;
                            n_rd      = osm_pkg::CNT_W'(1);
                            n_w       = '0;
                        end
                    endcase
                end
            end
            osm_pkg::S_QUERY_WAIT: begin
                n_res_value = rd_key;
            end
            osm_pkg::S_INS_SCAN: begin
                ram_we = 1'b1;
                if (rd_key > r_key) begin
                    // shift the larger entry up one slot, read the next one down
                    ram_wdata = rd_key;
                    n_pos     = r_pos - osm_pkg::ADDR_W'(1);
                end else begin
                    ram_wdata = r_key;
                    n_count   = r_count + osm_pkg::CNT_W'(1);
                end
            end
            osm_pkg::S_INS_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = r_key;
                n_count   = r_count + osm_pkg::CNT_W'(1);
            end
            osm_pkg::S_REM_SCAN: begin
                // data from address r_rd - 1; the write pointer never passes the read
                ram_waddr = r_w[osm_pkg::ADDR_W-1:0];
                ram_wdata = rd_key;
                ram_raddr = r_rd[osm_pkg::ADDR_W-1:0];
                if (rd_key != r_key) begin
                    ram_we = 1'b1;
                    n_w    = r_w + osm_pkg::CNT_W'(1);
                end
                if (r_rd == r_count) begin
                    n_count = (rd_key != r_key) ? (r_w + osm_pkg::CNT_W'(1)) : r_w;
                end else begin
                    n_rd = r_rd + osm_pkg::CNT_W'(1);
                end
            end
            osm_pkg::S_FINISH: begin
                if (out_load) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_count  = osm_pkg::COUNT_W'(r_count);
                    n_out_status = r_res_status;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= osm_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_pos        <= n_pos;
        r_rd         <= n_rd;
        r_w          <= n_w;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    assign o_valid        = r_out_valid;
    assign o_value        = r_out_value;
    assign o_stored_count = r_out_count;
    assign o_status       = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= osm_pkg::CNT_W'(osm_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_ins_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osm_pkg::S_INS_SCAN) |->
            (r_pos != '0 && osm_pkg::CNT_W'(r_pos) <= r_count))
        else $error("insert slot out of range");

    a_rem_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osm_pkg::S_REM_SCAN) |-> (r_w < r_rd && r_rd <= r_count))
        else $error("compaction pointers crossed");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == osm_pkg::ST_FULL) |->
            (o_stored_count == osm_pkg::COUNT_W'(osm_pkg::CAPACITY)))
        else $error("full status with store not full");

    a_finish_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == osm_pkg::S_FINISH && r_out_valid && !i_ready) |=>
            (r_state == osm_pkg::S_FINISH))
        else $error("result left finish while output busy");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for order_statistic_multiset. A shadow copy of
// the sorted store predicts every result when an operation transfers in;
// results are checked in order as they transfer out. Directed corner cases
// come first, then a fill to capacity, then random insert/remove/query mixes
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic signed [osm_pkg::KEY_W-1:0] value;
    logic [osm_pkg::COUNT_W-1:0]      count;
    logic [osm_pkg::STATUS_W-1:0]     status;
} t_osm_result;

class sorted_store_model;
    logic signed [osm_pkg::KEY_W-1:0] keys [osm_pkg::CAPACITY];
    int unsigned                      entries;
    t_osm_result                      expected_results [$];
    int                               mismatch_count;

    function new();
        entries        = 0;
        mismatch_count = 0;
    endfunction

    // called once per accepted operation, in transfer order
    function void apply_op(logic [osm_pkg::CMD_W-1:0] cmd,
                           logic signed [osm_pkg::KEY_W-1:0] key,
                           logic [osm_pkg::RANK_W-1:0] rank);
        t_osm_result res;
        int          pos;
        int          rd;
        int          wr;
        res.value  = '0;
        res.status = osm_pkg::ST_OK;
        if (cmd == osm_pkg::CMD_QUERY) begin
            if (rank == 0 || rank > entries)
                res.status = osm_pkg::ST_BAD_RANK;
            else
                res.value = keys[entries - rank];
        end else if (cmd == osm_pkg::CMD_INSERT) begin
            if (entries >= osm_pkg::CAPACITY) begin
                res.status = osm_pkg::ST_FULL;
            end else begin
                // new copy goes after any equal keys
                pos = entries;
                while (pos > 0 && keys[pos-1] > key) begin
                    keys[pos] = keys[pos-1];
                    pos--;
                end
                keys[pos] = key;
                entries++;
            end
        end else begin
            // anything with bit 1 set removes every copy
            wr = 0;
            for (rd = 0; rd < entries; rd++) begin
                if (keys[rd] != key) begin
                    keys[wr] = keys[rd];
                    wr++;
                end
            end
            entries = wr;
        end
        res.count = entries[osm_pkg::COUNT_W-1:0];
        expected_results.push_back(res);
    endfunction

    function void check_result(logic signed [osm_pkg::KEY_W-1:0] value,
                               logic [osm_pkg::COUNT_W-1:0] count,
                               logic [osm_pkg::STATUS_W-1:0] status);
        t_osm_result exp_r;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: value %0d count %0d status %0d",
                         value, count, status);
            return;
        end
        exp_r = expected_results.pop_front();
        if (exp_r.value !== value || exp_r.count !== count || exp_r.status !== status) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: expected value %0d count %0d status %0d, got %0d %0d %0d",
                         exp_r.value, exp_r.count, exp_r.status, value, count, status);
        end
    endfunction
endclass

module testbench;

    localparam logic [osm_pkg::CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int                        CYCLE_LIMIT = 6000000;
    localparam int                        TAIL_CYCLES = 1100;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_ready;
    logic [osm_pkg::CMD_W-1:0]          i_cmd;
    logic signed [osm_pkg::KEY_W-1:0]   i_key;
    logic [osm_pkg::RANK_W-1:0]         i_rank;
    logic                               o_valid;
    logic                               i_ready;
    logic signed [osm_pkg::KEY_W-1:0]   o_value;
    logic [osm_pkg::COUNT_W-1:0]        o_stored_count;
    logic [osm_pkg::STATUS_W-1:0]       o_status;

    sorted_store_model shadow;
    bit                send_idle = 1'b1;
    bit                recv_idle = 1'b1;
    int                cycle_count = 0;

    order_statistic_multiset dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_rank         (i_rank),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_value        (o_value),
        .o_stored_count (o_stored_count),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("order_statistic_multiset regression: fail");
            $finish;
        end
    end

    // returns at the edge where the operation transfers; valid stays high
    task automatic send_op(input logic [osm_pkg::CMD_W-1:0] cmd,
                           input logic signed [osm_pkg::KEY_W-1:0] key,
                           input logic [osm_pkg::RANK_W-1:0] rank);
        int gap;
        if ($urandom_range(47, 0) == 0)
            send_idle = !send_idle;
        gap = send_idle ? $urandom_range(8, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_key   <= key;
        i_rank  <= rank;
        do @(posedge i_clk); while (!o_ready);
        shadow.apply_op(cmd, key, rank);
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (shadow.expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // result side
    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(63, 0) == 0)
                recv_idle = !recv_idle;
            gap = recv_idle ? $urandom_range(8, 0) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            shadow.check_result(o_value, o_stored_count, o_status);
        end
    end

    initial begin : stimulus
        logic signed [osm_pkg::KEY_W-1:0] fill_keys [8];
        logic signed [osm_pkg::KEY_W-1:0] key_pool [12];
        logic signed [osm_pkg::KEY_W-1:0] k;
        logic signed [osm_pkg::KEY_W-1:0] tmp;
        logic [osm_pkg::RANK_W-1:0]       qrank;
        int                               i;
        int                               j;
        int                               n;
        int                               sel;
        int                               r;

        shadow = new();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd   <= osm_pkg::CMD_QUERY;
        i_key   <= '0;
        i_rank  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: empty store, extreme keys, duplicates, bad ranks
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd0);
        send_op(osm_pkg::CMD_QUERY, -32'sd1, 11'd1);
        send_op(osm_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 11'd0);
        send_op(osm_pkg::CMD_INSERT, 32'sh8000_0000, 11'h7FF);
        send_op(osm_pkg::CMD_INSERT, 32'sd0, 11'd0);
        send_op(osm_pkg::CMD_INSERT, -32'sd1, 11'd0);
        send_op(osm_pkg::CMD_INSERT, -32'sd1, 11'd0);
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd1);
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd5);
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd6);
        send_op(osm_pkg::CMD_QUERY, 32'sh7FFF_FFFF, 11'h7FF);
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd3);
        send_op(osm_pkg::CMD_REMOVE, 32'sd12345, 11'd0);
        send_op(osm_pkg::CMD_REMOVE, -32'sd1, 11'd0);
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd3);
        send_op(osm_pkg::CMD_INSERT, 32'sh5555_5555, 11'h555);
        send_op(osm_pkg::CMD_INSERT, 32'shAAAA_AAAA, 11'h2AA);
        send_op(CMD_UNUSED, 32'sd0, 11'd0);
        send_op(osm_pkg::CMD_QUERY, 32'sd0, 11'd2);
        send_op(osm_pkg::CMD_REMOVE, 32'sh7FFF_FFFF, 11'd0);
        send_op(osm_pkg::CMD_REMOVE, 32'sh8000_0000, 11'd0);
        send_op(osm_pkg::CMD_REMOVE, 32'sh5555_5555, 11'd0);
        send_op(CMD_UNUSED, 32'shAAAA_AAAA, 11'd0);
        send_op(osm_pkg::CMD_REMOVE, 32'sd7, 11'd0);
        wait_results_done();

        // fill to capacity; ascending groups keep every insert at the top
        for (i = 0; i < 8; i++)
            fill_keys[i] = $urandom;
        for (i = 1; i < 8; i++) begin
            tmp = fill_keys[i];
            j = i;
            while (j > 0 && fill_keys[j-1] > tmp) begin
                fill_keys[j] = fill_keys[j-1];
                j--;
            end
            fill_keys[j] = tmp;
        end
        for (i = 0; i < 8; i++)
            repeat (osm_pkg::CAPACITY / 8)
                send_op(osm_pkg::CMD_INSERT, fill_keys[i],
                        osm_pkg::RANK_W'($urandom_range(2047, 0)));
        wait_results_done();

        repeat (4) send_op(osm_pkg::CMD_INSERT, $urandom,
                           osm_pkg::RANK_W'($urandom_range(2047, 0)));
        send_op(osm_pkg::CMD_QUERY, $urandom, 11'd1);
        send_op(osm_pkg::CMD_QUERY, $urandom, osm_pkg::RANK_W'(osm_pkg::CAPACITY));
        send_op(osm_pkg::CMD_QUERY, $urandom, osm_pkg::RANK_W'(osm_pkg::CAPACITY + 1));
        send_op(osm_pkg::CMD_QUERY, $urandom, 11'd0);
        repeat (6) send_op(osm_pkg::CMD_QUERY, $urandom,
                           osm_pkg::RANK_W'($urandom_range(osm_pkg::CAPACITY, 1)));
        send_op(osm_pkg::CMD_INSERT, fill_keys[7], 11'd0);
        send_op(osm_pkg::CMD_REMOVE, fill_keys[3], osm_pkg::RANK_W'($urandom_range(2047, 0)));
        repeat (3) send_op(osm_pkg::CMD_INSERT, $urandom,
                           osm_pkg::RANK_W'($urandom_range(2047, 0)));
        repeat (4) send_op(osm_pkg::CMD_QUERY, $urandom,
                           osm_pkg::RANK_W'($urandom_range(shadow.entries, 1)));
        while (shadow.entries != 0)
            send_op($urandom_range(1, 0) ? osm_pkg::CMD_REMOVE : CMD_UNUSED, shadow.keys[0],
                    osm_pkg::RANK_W'($urandom_range(2047, 0)));
        wait_results_done();

        // random mix; pool keys make duplicates and hitting removes common
        key_pool[0] = 32'sd0;
        key_pool[1] = -32'sd1;
        key_pool[2] = 32'sd1;
        key_pool[3] = 32'sh7FFF_FFFF;
        key_pool[4] = 32'sh8000_0000;
        for (i = 5; i < 12; i++)
            key_pool[i] = $urandom;
        for (n = 0; n < 230; n++) begin
            if (n == 115)
                wait_results_done();
            sel = $urandom_range(99, 0);
            k = ($urandom_range(9, 0) < 6) ? key_pool[$urandom_range(11, 0)] : $urandom;
            if (sel < 45) begin
                send_op(osm_pkg::CMD_INSERT, k, osm_pkg::RANK_W'($urandom_range(2047, 0)));
            end else if (sel < 65) begin
                send_op((sel < 60) ? osm_pkg::CMD_REMOVE : CMD_UNUSED, k,
                        osm_pkg::RANK_W'($urandom_range(2047, 0)));
            end else begin
                r = $urandom_range(99, 0);
                if (r < 60 && shadow.entries > 0)
                    qrank = osm_pkg::RANK_W'($urandom_range(shadow.entries, 1));
                else if (r < 70)
                    qrank = '0;
                else if (r < 85)
                    qrank = osm_pkg::RANK_W'(shadow.entries + 1);
                else
                    qrank = osm_pkg::RANK_W'($urandom_range(2047, 0));
                send_op(osm_pkg::CMD_QUERY, $urandom, qrank);
            end
        end
        i_valid <= 1'b0;

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (shadow.mismatch_count == 0 && shadow.expected_results.size() == 0)
            $display("order_statistic_multiset regression: pass");
        else
            $display("order_statistic_multiset regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
src/osm_pkg.sv
src/osm_ram.sv
src/order_statistic_multiset.sv
sim/testbench.sv
